// ----- hw/rtl/iafmt_pkg.sv -----
// Shared types and constants for the integer to ASCII field formatter.
package iafmt_pkg;

   localparam int MAX_FIELD_WIDTH = 64;
   localparam int DIGIT_SLOTS     = 20;
   localparam int VALUE_BITS      = 64;
   localparam int WIDTH_BITS      = 7;
   localparam int DIGIT_IDX_BITS  = $clog2(DIGIT_SLOTS);
   localparam int STEP_BITS       = $clog2(VALUE_BITS);

   localparam logic [1:0] OP_UDEC = 2'd0;
   localparam logic [1:0] OP_SDEC = 2'd1;
   localparam logic [1:0] OP_HEX  = 2'd2;

   localparam logic [7:0] CHR_SPACE   = 8'h20;
   localparam logic [7:0] CHR_MINUS   = 8'h2D;
   localparam logic [7:0] CHR_ZERO    = 8'h30;
   localparam logic [7:0] CHR_UPPER_A = 8'h41;
   localparam logic [7:0] CHR_LOWER_A = 8'h61;

   typedef struct packed {
      logic [1:0]            op;
      logic [VALUE_BITS-1:0] value;
      logic                  upper_case;
      logic [WIDTH_BITS-1:0] field_width;
      logic                  zero_pad;
      logic                  left_justify;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } rsp_payload_type;

   // ASCII code of one digit, hexadecimal letters in the chosen case
   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] base;
      begin
         base = upper ? CHR_UPPER_A : CHR_LOWER_A;
         if (d < 4'd10) begin
            digit_char = CHR_ZERO + {4'b0, d};
         end else begin
            digit_char = base + {4'b0, d} - 8'd10;
         end
      end
   endfunction

endpackage

// ----- hw/rtl/integer_to_ascii_field_formatter_top.sv -----
// Integer to ASCII field formatter: sequencer, shift-and-add-3 converter, character output.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_data  (iafmt_pkg::req_payload_type)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_data  (iafmt_pkg::rsp_payload_type)
//
// Decimal items pass through the shared shift-and-add-3 converter (one value bit per
// cycle); hexadecimal items skip it. A leading-digit scan follows, and the field leaves
// at one beat per cycle while rsp_ready is high, up to 64 beats. req_ready is high only
// while idle. Reset is synchronous and clears the sequencer and the output valid.
// rsp_ready low holds the output register and, in the emitting states, the sequencer; the
// last beat may wait in the output register while the next item is accepted.
module integer_to_ascii_field_formatter_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  iafmt_pkg::req_payload_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output iafmt_pkg::rsp_payload_type rsp_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_PRE   = 3'd3;
   localparam logic [2:0] ST_SIGN  = 3'd4;
   localparam logic [2:0] ST_ZERO  = 3'd5;
   localparam logic [2:0] ST_DIGIT = 3'd6;
   localparam logic [2:0] ST_POST  = 3'd7;

   localparam int VB = iafmt_pkg::VALUE_BITS;
   localparam int WB = iafmt_pkg::WIDTH_BITS;
   localparam int DB = iafmt_pkg::DIGIT_IDX_BITS;
   localparam int SB = iafmt_pkg::STEP_BITS;
   localparam int NS = iafmt_pkg::DIGIT_SLOTS;

   logic [2:0]             state_ff,   state_in;
   logic [VB-1:0]          bin_ff,     bin_in;
   logic [NS-1:0][3:0]     bcd_ff,     bcd_in;
   logic [SB-1:0]          step_ff,    step_in;
   logic [DB-1:0]          dig_ff,     dig_in;
   logic [WB-1:0]          pad_ff,     pad_in;
   logic [WB-1:0]          width_ff,   width_in;
   logic                   neg_ff,     neg_in;
   logic                   upper_ff,   upper_in;
   logic                   zpad_ff,    zpad_in;
   logic                   left_ff,    left_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   iafmt_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [NS-1:0][3:0]     bcd_adj;
   logic [VB-1:0]          mag;
   logic                   in_neg;
   logic                   emitting;
   logic                   emit_go;
   logic [3:0]             cur_digit;
   logic [WB-1:0]          len;
   logic [WB-1:0]          padlen;
   logic [7:0]             emit_char;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign in_neg = (req_data.op == iafmt_pkg::OP_SDEC) && req_data.value[VB-1];
   assign mag    = in_neg ? (~req_data.value + {{(VB-1){1'b0}}, 1'b1}) : req_data.value;

   // add 3 to every BCD digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < NS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? (bcd_ff[i] + 4'd3) : bcd_ff[i];
      end
   end

   assign cur_digit = bcd_ff[dig_ff];
   assign len       = WB'(dig_ff) + WB'(1) + WB'(neg_ff);
   assign padlen    = (width_ff > len) ? (width_ff - len) : '0;

   assign emitting = (state_ff == ST_PRE) || (state_ff == ST_SIGN) || (state_ff == ST_ZERO) ||
                     (state_ff == ST_DIGIT) || (state_ff == ST_POST);
   assign emit_go  = emitting && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      unique case (state_ff)
         ST_PRE, ST_POST: emit_char = iafmt_pkg::CHR_SPACE;
         ST_SIGN:         emit_char = iafmt_pkg::CHR_MINUS;
         ST_ZERO:         emit_char = iafmt_pkg::CHR_ZERO;
         ST_DIGIT:        emit_char = iafmt_pkg::digit_char(cur_digit, upper_ff);
         default:         emit_char = iafmt_pkg::CHR_SPACE;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      step_in      = step_ff;
      dig_in       = dig_ff;
      pad_in       = pad_ff;
      width_in     = width_ff;
      neg_in       = neg_ff;
      upper_in     = upper_ff;
      zpad_in      = zpad_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in   = in_neg;
               upper_in = req_data.upper_case;
               zpad_in  = req_data.zero_pad;
               left_in  = req_data.left_justify;
               width_in = (req_data.field_width > WB'(iafmt_pkg::MAX_FIELD_WIDTH)) ?
                          WB'(iafmt_pkg::MAX_FIELD_WIDTH) : req_data.field_width;
               dig_in   = DB'(NS - 1);
               step_in  = '1;
               if (req_data.op == iafmt_pkg::OP_HEX) begin
                  // nibbles are the digits already
                  bcd_in   = {(NS * 4)'(mag)};
                  state_in = ST_SCAN;
               end else begin
                  bin_in   = mag;
                  bcd_in   = '0;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            bcd_in  = (NS * 4)'({bcd_adj, bin_ff[VB-1]});
            bin_in  = {bin_ff[VB-2:0], 1'b0};
            step_in = step_ff - SB'(1);
            if (step_ff == '0) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // drop leading zero digits, keep at least one
            if (cur_digit == 4'd0 && dig_ff != '0) begin
               dig_in = dig_ff - DB'(1);
            end else begin
               pad_in = padlen;
               if (!left_ff && !zpad_ff && padlen != '0) begin
                  state_in = ST_PRE;
               end else if (neg_ff) begin
                  state_in = ST_SIGN;
               end else if (!left_ff && zpad_ff && padlen != '0) begin
                  state_in = ST_ZERO;
               end else begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_PRE: begin
            if (emit_go) begin
               pad_in = pad_ff - WB'(1);
               if (pad_ff == WB'(1)) begin
                  state_in = neg_ff ? ST_SIGN : ST_DIGIT;
               end
            end
         end
         ST_SIGN: begin
            if (emit_go) begin
               state_in = (!left_ff && zpad_ff && pad_ff != '0) ? ST_ZERO : ST_DIGIT;
            end
         end
         ST_ZERO: begin
            if (emit_go) begin
               pad_in = pad_ff - WB'(1);
               if (pad_ff == WB'(1)) begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_DIGIT: begin
            if (emit_go) begin
               dig_in = dig_ff - DB'(1);
               if (dig_ff == '0) begin
                  state_in = (left_ff && pad_ff != '0) ? ST_POST : ST_IDLE;
               end
            end
         end
         ST_POST: begin
            if (emit_go) begin
               pad_in = pad_ff - WB'(1);
               if (pad_ff == WB'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit_go) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.char_code = emit_char;
         rsp_data_in.last_char = (state_in == ST_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      step_ff     <= step_in;
      dig_ff      <= dig_in;
      pad_ff      <= pad_in;
      width_ff    <= width_in;
      neg_ff      <= neg_in;
      upper_ff    <= upper_in;
      zpad_ff     <= zpad_in;
      left_ff     <= left_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- hw/rtl/iafmt_checker.sv -----
// Port-level assertions for the integer to ASCII field formatter, bound to the top level.
module iafmt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input iafmt_pkg::req_payload_type req_data,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input iafmt_pkg::rsp_payload_type rsp_data
);

   // a stalled beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // nothing is shown straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // once an item is taken the block is busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accept");

   // a field in mid-flight keeps the input closed
   a_mid_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_char |-> !req_ready)
      else $error("req_ready high while a field is unfinished");

   // an accept starts with work in the sequencer before any beat of the new field
   a_no_early_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("rsp beat on the cycle after an accept");

endmodule

bind integer_to_ascii_field_formatter_top iafmt_checker u_iafmt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- sim/iafmt_field_checker.sv -----
// Checker for the integer to ASCII field formatter: predicts each field and compares every beat.
module iafmt_field_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  iafmt_pkg::req_payload_type req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  iafmt_pkg::rsp_payload_type rsp_data,
   output int                         error_count,
   output int                         pending_beats
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   iafmt_pkg::rsp_payload_type expected_chars[$];

   // Append the characters of one formatted field to the expected queue
   function automatic void format_field(input iafmt_pkg::req_payload_type item);
      logic [63:0] magnitude;
      logic [63:0] remainder;
      logic [7:0]  digit_buf[iafmt_pkg::DIGIT_SLOTS];
      logic [7:0]  letter_base;
      logic [7:0]  field_chars[$];
      logic [3:0]  nibble;
      iafmt_pkg::rsp_payload_type beat;
      int          n_digits;
      int          field_len;
      int          text_len;
      int          pad_len;
      bit          negative;
      bit          is_hex;
      begin
         n_digits    = 0;
         is_hex      = (item.op == iafmt_pkg::OP_HEX);
         letter_base = item.upper_case ? iafmt_pkg::CHR_UPPER_A : iafmt_pkg::CHR_LOWER_A;
         field_len   = (item.field_width > iafmt_pkg::MAX_FIELD_WIDTH) ?
                       iafmt_pkg::MAX_FIELD_WIDTH : int'(item.field_width);
         negative    = (item.op == iafmt_pkg::OP_SDEC) && item.value[63];
         magnitude   = negative ? (~item.value + 64'd1) : item.value;

         if (magnitude == 64'd0) begin
            digit_buf[0] = iafmt_pkg::CHR_ZERO;
            n_digits = 1;
         end
         // Digits come out least significant first
         while (magnitude != 64'd0 && n_digits < iafmt_pkg::DIGIT_SLOTS) begin
            if (is_hex) begin
               nibble = magnitude[3:0];
               digit_buf[n_digits] = (nibble < 4'd10) ?
                                     iafmt_pkg::CHR_ZERO + {4'b0, nibble} :
                                     letter_base + {4'b0, nibble} - 8'd10;
               magnitude = magnitude >> 4;
            end else begin
               remainder = magnitude % 64'd10;
               digit_buf[n_digits] = iafmt_pkg::CHR_ZERO + remainder[7:0];
               magnitude = magnitude / 64'd10;
            end
            n_digits++;
         end

         text_len = n_digits + (negative ? 1 : 0);
         pad_len  = (field_len > text_len) ? field_len - text_len : 0;

         if (!item.left_justify && !item.zero_pad) begin
            repeat (pad_len) field_chars.push_back(iafmt_pkg::CHR_SPACE);
         end
         if (negative) begin
            field_chars.push_back(iafmt_pkg::CHR_MINUS);
         end
         if (!item.left_justify && item.zero_pad) begin
            repeat (pad_len) field_chars.push_back(iafmt_pkg::CHR_ZERO);
         end
         for (int i = n_digits - 1; i >= 0; i--) begin
            field_chars.push_back(digit_buf[i]);
         end
         if (item.left_justify) begin
            repeat (pad_len) field_chars.push_back(iafmt_pkg::CHR_SPACE);
         end

         foreach (field_chars[i]) begin
            beat.char_code = field_chars[i];
            beat.last_char = (i == field_chars.size() - 1);
            expected_chars.push_back(beat);
         end
      end
   endfunction

   always @(posedge clock) begin
      iafmt_pkg::rsp_payload_type want;
      if (reset) begin
         expected_chars.delete();
         error_count   <= 0;
         pending_beats <= 0;
      end else begin
         // Compare the outgoing beat first: it never belongs to an item taken on this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               if (error_count < REPORT_LIMIT) begin
                  $display("%0t: unexpected beat char_code=%02h last_char=%0b",
                           $realtime, rsp_data.char_code, rsp_data.last_char);
               end
               error_count <= error_count + 1;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.char_code !== want.char_code ||
                   rsp_data.last_char !== want.last_char) begin
                  if (error_count < REPORT_LIMIT) begin
                     $display("%0t: mismatch char exp=%02h got=%02h last exp=%0b got=%0b",
                              $realtime, want.char_code, rsp_data.char_code,
                              want.last_char, rsp_data.last_char);
                  end
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            format_field(req_data);
         end
         pending_beats <= expected_chars.size();
      end
   end

endmodule

// ----- sim/integer_to_ascii_field_formatter_top_tb.sv -----
// Testbench top for the integer to ASCII field formatter: clock, reset, stimulus and verdict.
module integer_to_ascii_field_formatter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_SPARE      = 2'd3;
   localparam int         RANDOM_FIELDS = 392;
   localparam int         STALL_LIMIT   = 4000;
   localparam int         DRAIN_CYCLES  = 200;
   localparam int         IDLE_PERCENT  = 18;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   iafmt_pkg::req_payload_type req_data;
   logic                       rsp_valid;
   logic                       rsp_ready;
   iafmt_pkg::rsp_payload_type rsp_data;

   int error_count;
   int pending_beats;
   int quiet_cycles;
   bit steady_phase;

   always #5ns clock = ~clock;

   integer_to_ascii_field_formatter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   iafmt_field_checker field_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_beats (pending_beats)
   );

   function automatic iafmt_pkg::req_payload_type make_field(input logic [1:0]  op,
                                                             input logic [63:0] value,
                                                             input logic        upper_case,
                                                             input logic [6:0]  field_width,
                                                             input logic        zero_pad,
                                                             input logic        left_justify);
      iafmt_pkg::req_payload_type item;
      begin
         item.op           = op;
         item.value        = value;
         item.upper_case   = upper_case;
         item.field_width  = field_width;
         item.zero_pad     = zero_pad;
         item.left_justify = left_justify;
         return item;
      end
   endfunction

   // Mix full-range values with short positives, short negatives and corner values
   function automatic logic [63:0] random_value();
      logic [63:0] raw;
      logic [63:0] mask;
      begin
         raw  = {$urandom, $urandom};
         mask = (64'd1 << $urandom_range(63, 1)) - 64'd1;
         case ($urandom_range(3))
            0: return raw;
            1: return raw & mask;
            2: return ~(raw & mask);
            default: begin
               case ($urandom_range(4))
                  0: return 64'd0;
                  1: return 64'd1;
                  2: return {1'b1, 63'd0};
                  3: return {1'b0, {63{1'b1}}};
                  default: return {64{1'b1}};
               endcase
            end
         endcase
      end
   endfunction

   function automatic iafmt_pkg::req_payload_type random_field();
      logic [1:0] op;
      logic [6:0] field_width;
      int         pick;
      begin
         pick = $urandom_range(19);
         op = (pick == 0) ? OP_SPARE :
              (pick < 7)  ? iafmt_pkg::OP_UDEC :
              (pick < 13) ? iafmt_pkg::OP_SDEC : iafmt_pkg::OP_HEX;
         // Keep most fields short; a few go wide or saturate
         field_width = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 25))
                                                : 7'($urandom_range(24));
         return make_field(op, random_value(), 1'($urandom), field_width,
                           1'($urandom), 1'($urandom));
      end
   endfunction

   // Present one field request and hold it until accepted; returns at a falling edge
   task automatic send_field(input iafmt_pkg::req_payload_type item);
      begin
         while (!steady_phase && $urandom_range(99) < IDLE_PERCENT) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
         req_valid = 1'b1;
         req_data  = item;
         do @(posedge clock); while (!req_ready);
         @(negedge clock);
      end
   endtask

   // Result side back-pressure
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = steady_phase || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: give up after a long run of cycles with no beat in either direction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      steady_phase = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed fields
      send_field(make_field(iafmt_pkg::OP_UDEC, 64'd0, 1'b0, 7'd0, 1'b0, 1'b0));
      send_field(make_field(iafmt_pkg::OP_UDEC, {64{1'b1}}, 1'b0, 7'd0, 1'b0, 1'b0));
      send_field(make_field(iafmt_pkg::OP_SDEC, {1'b1, 63'd0}, 1'b0, 7'd0, 1'b0, 1'b0));
      send_field(make_field(iafmt_pkg::OP_SDEC, {1'b0, {63{1'b1}}}, 1'b0, 7'd0, 1'b0, 1'b0));
      send_field(make_field(iafmt_pkg::OP_SDEC, {64{1'b1}}, 1'b0, 7'd5, 1'b1, 1'b0));
      send_field(make_field(iafmt_pkg::OP_SDEC, -64'sd42, 1'b0, 7'd8, 1'b0, 1'b0));
      send_field(make_field(iafmt_pkg::OP_SDEC, -64'sd42, 1'b0, 7'd8, 1'b1, 1'b1));
      send_field(make_field(iafmt_pkg::OP_SDEC, -64'sd7, 1'b0, 7'd6, 1'b0, 1'b1));
      send_field(make_field(iafmt_pkg::OP_SDEC, 64'd0, 1'b0, 7'd3, 1'b1, 1'b0));
      send_field(make_field(iafmt_pkg::OP_HEX, 64'hDEAD_BEEF, 1'b1, 7'd0, 1'b0, 1'b0));
      send_field(make_field(iafmt_pkg::OP_HEX, 64'hABCD_EF01_2345_6789, 1'b0, 7'd12,
                            1'b1, 1'b0));
      send_field(make_field(iafmt_pkg::OP_HEX, {64{1'b1}}, 1'b1, 7'd64, 1'b1, 1'b0));
      send_field(make_field(iafmt_pkg::OP_HEX, {1'b1, 63'd0}, 1'b0, 7'd3, 1'b0, 1'b0));
      send_field(make_field(iafmt_pkg::OP_HEX, 64'd0, 1'b1, 7'd3, 1'b1, 1'b1));
      send_field(make_field(iafmt_pkg::OP_UDEC, 64'd7, 1'b0, 7'd127, 1'b1, 1'b0));
      send_field(make_field(iafmt_pkg::OP_UDEC, 64'd123, 1'b0, 7'd100, 1'b0, 1'b1));
      send_field(make_field(iafmt_pkg::OP_UDEC, 64'd1, 1'b0, 7'd1, 1'b0, 1'b0));
      send_field(make_field(iafmt_pkg::OP_UDEC, 64'd987654321, 1'b0, 7'd4, 1'b1, 1'b0));
      send_field(make_field(OP_SPARE, 64'd12345, 1'b1, 7'd10, 1'b1, 1'b0));
      send_field(make_field(OP_SPARE, {1'b1, 63'd0}, 1'b0, 7'd22, 1'b0, 1'b0));
      send_field(make_field(iafmt_pkg::OP_SDEC, -64'sd1000, 1'b0, 7'd21, 1'b0, 1'b0));
      send_field(make_field(iafmt_pkg::OP_HEX, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0, 7'd65,
                            1'b0, 1'b1));

      // Random fields
      for (int n = 0; n < RANDOM_FIELDS; n++) begin
         if (n == 150) begin
            // Hold the sender until every outstanding beat has drained
            req_valid = 1'b0;
            while (pending_beats != 0) @(negedge clock);
         end
         if (n == 230) steady_phase = 1'b1;
         if (n == 300) steady_phase = 1'b0;
         send_field(random_field());
      end
      req_valid = 1'b0;

      while (pending_beats != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0 && pending_beats == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
